### design/mi_pkg.sv
// ----------------------------------------------------------------------------
// Modular inverse package
// Shared widths, word types, sequencer states and control structs.
// ----------------------------------------------------------------------------
package mi_pkg;

  localparam int WORD_BITS  = 31;
  localparam int SHIFT_BITS = $clog2(WORD_BITS);
  localparam int COEF_BITS  = WORD_BITS + 3;
  localparam int DIFF_BITS  = WORD_BITS + 2;

  typedef logic [WORD_BITS-1:0]         word_t;
  typedef logic signed [COEF_BITS-1:0]  coef_t;
  typedef logic [SHIFT_BITS-1:0]        shift_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALIGN,
    ST_DIV,
    ST_FIX_NEG,
    ST_FIX_GE
  } state_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD,
    OP_SHIFT,
    OP_STEP,
    OP_FIX_NEG
  } op_t;

  typedef struct packed {
    op_t  op;
    logic cmp_dbl;
    logic in_ready;
    logic out_load;
  } seq_ctrl_t;

  typedef struct packed {
    logic b_zero;
    logic fits;
    logic k_zero;
  } dp_stat_t;

endpackage

### design/mi_datapath.sv
// ----------------------------------------------------------------------------
// Modular inverse datapath
// Remainder and coefficient registers around one shared compare/subtract unit;
// runs shift-subtract division rounds of the extended Euclidean algorithm.
// ----------------------------------------------------------------------------
module mi_datapath (
  input  logic              clk,
  input  mi_pkg::seq_ctrl_t ctrl,
  input  mi_pkg::word_t     load_value,
  input  mi_pkg::word_t     modulus,
  output mi_pkg::dp_stat_t  stat,
  output mi_pkg::word_t     res_inverse,
  output logic              res_exists
);

  mi_pkg::word_t  a_r, a_nxt;
  mi_pkg::word_t  b_r, b_nxt;
  mi_pkg::word_t  d_r, d_nxt;
  mi_pkg::coef_t  sa_r, sa_nxt;
  mi_pkg::coef_t  sb_r, sb_nxt;
  mi_pkg::coef_t  ds_r, ds_nxt;
  mi_pkg::shift_t k_r, k_nxt;

  logic [mi_pkg::DIFF_BITS-1:0] opnd;
  logic [mi_pkg::DIFF_BITS-1:0] diff;
  logic                         fits;
  mi_pkg::word_t                a_rem;
  mi_pkg::coef_t                sa_sub;
  mi_pkg::coef_t                sa_rem;
  mi_pkg::coef_t                mod_c;
  mi_pkg::coef_t                sa_fix;
  logic                         sa_ge;

  assign mod_c = mi_pkg::coef_t'({3'b000, modulus});

  // shared compare/subtract unit
  always_comb begin
    if (ctrl.cmp_dbl) begin
      opnd = {1'b0, d_r, 1'b0};
    end else begin
      opnd = {2'b00, d_r};
    end
    diff = {2'b00, a_r} - opnd;
  end

  assign fits   = ~diff[mi_pkg::DIFF_BITS-1];
  assign a_rem  = fits ? diff[mi_pkg::WORD_BITS-1:0] : a_r;
  assign sa_sub = sa_r - ds_r;
  assign sa_rem = fits ? sa_sub : sa_r;

  always_comb begin
    a_nxt  = a_r;
    b_nxt  = b_r;
    d_nxt  = d_r;
    sa_nxt = sa_r;
    sb_nxt = sb_r;
    ds_nxt = ds_r;
    k_nxt  = k_r;
    case (ctrl.op)
      mi_pkg::OP_LOAD: begin
        a_nxt  = load_value;
        b_nxt  = modulus;
        d_nxt  = modulus;
        sa_nxt = mi_pkg::coef_t'(1);
        sb_nxt = '0;
        ds_nxt = '0;
        k_nxt  = '0;
      end
      mi_pkg::OP_SHIFT: begin
        d_nxt  = {d_r[mi_pkg::WORD_BITS-2:0], 1'b0};
        ds_nxt = ds_r <<< 1;
        k_nxt  = k_r + mi_pkg::shift_t'(1);
      end
      mi_pkg::OP_STEP: begin
        if (k_r == '0) begin
          a_nxt  = b_r;
          b_nxt  = a_rem;
          d_nxt  = a_rem;
          sa_nxt = sb_r;
          sb_nxt = sa_rem;
          ds_nxt = sa_rem;
        end else begin
          a_nxt  = a_rem;
          sa_nxt = sa_rem;
          d_nxt  = d_r >> 1;
          ds_nxt = ds_r >>> 1;
          k_nxt  = k_r - mi_pkg::shift_t'(1);
        end
      end
      mi_pkg::OP_FIX_NEG: begin
        if (sa_r[mi_pkg::COEF_BITS-1]) begin
          sa_nxt = sa_r + mod_c;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    a_r  <= a_nxt;
    b_r  <= b_nxt;
    d_r  <= d_nxt;
    sa_r <= sa_nxt;
    sb_r <= sb_nxt;
    ds_r <= ds_nxt;
    k_r  <= k_nxt;
  end

  assign stat.b_zero = (b_r == '0);
  assign stat.fits   = fits;
  assign stat.k_zero = (k_r == '0);

  assign sa_fix = sa_r - mod_c;
  assign sa_ge  = ~sa_fix[mi_pkg::COEF_BITS-1];

  assign res_exists  = (modulus != '0) && (a_r == mi_pkg::word_t'(1));

  always_comb begin
    if (!res_exists) begin
      res_inverse = '0;
    end else if (sa_ge) begin
      res_inverse = sa_fix[mi_pkg::WORD_BITS-1:0];
    end else begin
      res_inverse = sa_r[mi_pkg::WORD_BITS-1:0];
    end
  end

endmodule

### design/mi_ctrl.sv
// ----------------------------------------------------------------------------
// Modular inverse sequencer
// Steps the datapath through align, divide and final reduction per word.
// ----------------------------------------------------------------------------
module mi_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              slot_free,
  input  mi_pkg::dp_stat_t  stat,
  output mi_pkg::seq_ctrl_t ctrl
);

  mi_pkg::state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mi_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = mi_pkg::ST_ALIGN;
        end
      end
      mi_pkg::ST_ALIGN: begin
        if (stat.b_zero) begin
          state_nxt = mi_pkg::ST_FIX_NEG;
        end else if (!stat.fits) begin
          state_nxt = mi_pkg::ST_DIV;
        end
      end
      mi_pkg::ST_DIV: begin
        if (stat.k_zero) begin
          state_nxt = mi_pkg::ST_ALIGN;
        end
      end
      mi_pkg::ST_FIX_NEG: begin
        state_nxt = mi_pkg::ST_FIX_GE;
      end
      mi_pkg::ST_FIX_GE: begin
        if (slot_free) begin
          state_nxt = mi_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mi_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl.op       = mi_pkg::OP_HOLD;
    ctrl.cmp_dbl  = 1'b0;
    ctrl.in_ready = 1'b0;
    ctrl.out_load = 1'b0;
    case (state_r)
      mi_pkg::ST_IDLE: begin
        ctrl.in_ready = 1'b1;
        if (in_valid) begin
          ctrl.op = mi_pkg::OP_LOAD;
        end
      end
      mi_pkg::ST_ALIGN: begin
        ctrl.cmp_dbl = 1'b1;
        if (!stat.b_zero && stat.fits) begin
          ctrl.op = mi_pkg::OP_SHIFT;
        end
      end
      mi_pkg::ST_DIV: begin
        ctrl.op = mi_pkg::OP_STEP;
      end
      mi_pkg::ST_FIX_NEG: begin
        ctrl.op = mi_pkg::OP_FIX_NEG;
      end
      mi_pkg::ST_FIX_GE: begin
        ctrl.out_load = slot_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mi_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### design/modular_inverse_top.sv
// ----------------------------------------------------------------------------
// Modular inverse top level
// Inverse of a word modulo a configured modulus by the extended Euclidean
// algorithm, with a flag telling whether the inverse exists.
//
// Channels: in_* carries the value to invert, out_* the inverse (tdata) and
// the exists flag (tuser), cfg_* writes the modulus. Write cfg only while
// idle. The shared compare/subtract unit works out one quotient bit per
// cycle while dividing. in_tready is high only while the sequencer is idle.
// Results sit in an output register, so the next word is taken while a
// result waits. If out_tready stays low, the sequencer holds its finished
// result until the register frees. Reset clears the sequencer and the
// output valid, and sets the modulus to 2.
// ----------------------------------------------------------------------------
module modular_inverse_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [31:0]                  in_tdata,   // [30:0] value
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [31:0]                  out_tdata,  // [30:0] inverse
  output logic                         out_tuser,  // [0] exists
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [mi_pkg::WORD_BITS-1:0] cfg_data    // [30:0] modulus
);

  mi_pkg::seq_ctrl_t ctrl;
  mi_pkg::dp_stat_t  stat;
  mi_pkg::word_t     modulus_r;
  mi_pkg::word_t     res_inverse;
  logic              res_exists;
  logic              out_valid_r;
  mi_pkg::word_t     out_inverse_r;
  logic              out_exists_r;
  logic              slot_free;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= mi_pkg::word_t'(2);
    end else if (cfg_valid) begin
      modulus_r <= cfg_data;
    end
  end

  assign slot_free = ~out_valid_r | out_tready;

  mi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .slot_free (slot_free),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  mi_datapath u_dp (
    .clk         (clk),
    .ctrl        (ctrl),
    .load_value  (in_tdata[mi_pkg::WORD_BITS-1:0]),
    .modulus     (modulus_r),
    .stat        (stat),
    .res_inverse (res_inverse),
    .res_exists  (res_exists)
  );

  assign in_tready = ctrl.in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      out_inverse_r <= res_inverse;
      out_exists_r  <= res_exists;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_inverse_r};
  assign out_tuser  = out_exists_r;

endmodule
